[rtl/arenv_pkg.sv]
package arenv_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EVENT,
    ST_DIV,
    ST_ADV,
    ST_X,
    ST_M1,
    ST_M2,
    ST_BURN,
    ST_IDX,
    ST_LO,
    ST_HI,
    ST_SOFT,
    ST_SATDIV,
    ST_SWAIT,
    ST_CON,
    ST_TONE,
    ST_FADE,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_GATE = 2'd1,
    ACT_TRIG = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_MANUAL   = 3'd0,
    REG_ATTACK   = 3'd1,
    REG_RELEASE  = 3'd2,
    REG_SAT_GAIN = 3'd3,
    REG_CON_GAIN = 3'd4,
    REG_TONE     = 3'd5,
    REG_FADE     = 3'd6,
    REG_ALPHA    = 3'd7
  } reg_e;

  localparam int unsigned CfgDataW   = 18;
  localparam int unsigned CordicSteps = 30;
  localparam longint      AtanOneQ30 = 64'sd1073741824;
  localparam longint      FiveQ30    = 64'sd5368709120;
  localparam logic [16:0] Q16One     = 17'd65536;
  localparam logic [16:0] SatMax     = 17'd104858;
  localparam logic [15:0] SatBias    = 16'd20480;
  // divide by 40960: shift by 13, then divide by 5 through a reciprocal
  localparam int unsigned SatShift      = 13;
  localparam logic [19:0] SatQMax       = 20'd524295;
  localparam logic [19:0] SatRecip      = 20'd838861;
  localparam int unsigned SatRecipShift = 22;
  localparam logic [9:0]  MsToUs     = 10'd1000;

  localparam longint ArcQ30 [CordicSteps] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  // shift toward zero
  function automatic longint shr_signed(input longint v, input int s);
    longint r;
    if (v >= 0) begin
      r = v >>> s;
    end else begin
      r = -((-v) >>> s);
    end
    return r;
  endfunction

  // atan(y / 2^30) in Q30, vectoring mode
  function automatic longint cordic_atan(input longint y_in);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = AtanOneQ30;
    y = y_in;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = shr_signed(y, i);
      dy = shr_signed(x, i);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ArcQ30[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ArcQ30[i];
      end
    end
    return z;
  endfunction

endpackage

[rtl/arenv_div.sv]
module arenv_div #(
  parameter int unsigned NumW = 44,
  parameter int unsigned DenW = 23
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[rtl/ar_envelope_grade_params.sv]
// Attack/release burn envelope with graded output parameters.
// Input channel (in_valid_i/in_ready_o): one word per event, action_i selects
// a time tick (elapsed_us_i), a gate or a trigger level update (level_i), or
// no update. Every accepted word yields exactly one result word on the output
// channel (out_valid_o/out_ready_i handshake) with all grade parameters.
// Config channel (cfg_valid_i/cfg_ready_o): register index plus data, always
// ready; write only while no word is in flight.
// A tick with nonzero time first runs the one-bit-per-cycle divider for the
// envelope step; the saturation scale is a shift plus a reciprocal multiply
// with its own 20x20 product. The other sequenced products share one 18x18
// multiplier reused by the sequencer. in_ready_o is high only while the
// sequencer is idle, so one word is processed at a time: the next word is
// taken in the cycle after the result loads.
// The result sits in an output register; a new word is accepted while it
// waits, and the sequencer holds its last step until the register frees.
// Reset: envelope, gate, trigger and one-shot clear, registers take their
// defaults; the soft clip table is a constant ROM, no init pass is needed.
module ar_envelope_grade_params #(
  parameter int unsigned SOFTCLIP_TABLE_DEPTH   = 256,
  parameter int unsigned ENVELOPE_FRACTION_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [19:0]                   elapsed_us_i,
  input  logic                          level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [16:0]                   burn_level_o,
  output logic [16:0]                   saturation_amount_o,
  output logic [16:0]                   contrast_amount_o,
  output logic signed [17:0]            tone_amount_o,
  output logic [16:0]                   black_fade_o,
  output logic [16:0]                   alpha_drop_o,
  output logic                          oneshot_active_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [arenv_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Frac  = ENVELOPE_FRACTION_BITS;
  localparam int unsigned Depth = SOFTCLIP_TABLE_DEPTH;
  localparam int unsigned NumW  = 20 + Frac;
  localparam int unsigned DenW  = 23;
  localparam int unsigned EnvW  = Frac + 1;
  localparam int unsigned AddrW = $clog2(Depth + 1);
  localparam int unsigned PosW  = 17 + AddrW;
  localparam logic [EnvW-1:0] EnvOne = EnvW'(1) << Frac;
  localparam longint AtanFull = arenv_pkg::cordic_atan(arenv_pkg::FiveQ30);

  // soft clip ROM
  logic [16:0] soft_rom [Depth+1];

  for (genvar k = 0; k <= Depth; k++) begin : g_rom
    localparam longint Yk = (arenv_pkg::FiveQ30 * k) / SOFTCLIP_TABLE_DEPTH;
    localparam longint Ak = arenv_pkg::cordic_atan(Yk);
    localparam longint Pk = (Ak < 0) ? 64'sd0 : Ak;
    localparam longint Vk = (Pk * 65536 + AtanFull / 2) / AtanFull;
    localparam longint Ck = (Vk > 65536) ? 64'sd65536 : Vk;
    assign soft_rom[k] = 17'(Ck);
  end

  function automatic logic [20:0] rnd16(input logic [35:0] p);
    logic [36:0] s;
    s = {1'b0, p} + 37'd32768;
    return s[36:16];
  endfunction

  function automatic logic [16:0] sat17(input logic [20:0] v);
    logic [16:0] r;
    if (v > 21'(arenv_pkg::Q16One)) begin
      r = arenv_pkg::Q16One;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  arenv_pkg::state_e state_q, state_d;

  // config registers
  logic [16:0] manual_q;
  logic [9:0]  attack_q;
  logic [12:0] release_q;
  logic [16:0] sat_gain_q;
  logic [16:0] con_gain_q;
  logic [17:0] tone_lift_q;
  logic [16:0] fade_depth_q;
  logic        alpha_q;

  // item state
  logic [EnvW-1:0] env_q;
  logic            gate_q;
  logic            trig_q;
  logic            oneshot_q;
  logic            rising_q;
  logic [1:0]      action_q;
  logic [19:0]     elapsed_q;
  logic            level_q;

  // datapath
  logic [35:0]      prod_q;
  logic [16:0]      burn_q;
  logic [AddrW-1:0] idx_q;
  logic [15:0]      frac_q;
  logic [16:0]      lo_q;
  logic [16:0]      rom_q;
  logic [16:0]      soft_q;
  logic [19:0]      satq_q;
  logic [39:0]      satr_q;
  logic [16:0]      satv_q;
  logic [16:0]      conv_q;
  logic [17:0]      tonev_q;

  // output register
  logic        out_valid_q;
  logic [16:0] burn_res_q;
  logic [16:0] sat_out_q;
  logic [16:0] con_out_q;
  logic [17:0] tone_out_q;
  logic [16:0] fade_out_q;
  logic [16:0] alpha_out_q;
  logic        oneshot_out_q;

  // control
  logic             prod_en;
  logic [17:0]      mul_a;
  logic [17:0]      mul_b;
  logic             div_start;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;
  logic             div_busy;
  logic [NumW-1:0]  div_quo;
  logic [AddrW-1:0] rom_addr;
  logic             out_load;

  // combinational values
  logic             ev_rising;
  logic [DenW-1:0]  ev_time_us;
  logic [20:0]      prod_rnd;
  logic [16:0]      x_val;
  logic [16:0]      x2_val;
  logic [16:0]      m_val;
  logic [16:0]      a_val;
  logic [16:0]      burn_val;
  logic [PosW-1:0]  pos_val;
  logic [PosW-17:0] pos_idx;
  logic [AddrW-1:0] idx_val;
  logic [15:0]      frac_val;
  logic [AddrW-1:0] idx_next;
  logic [16:0]      d_val;
  logic [16:0]      soft_val;
  logic [36:0]      sat_num;
  logic [23:0]      sat_shr;
  logic [19:0]      satq_val;
  logic [17:0]      sat_quo;
  logic [16:0]      sat_val;
  logic             tone_neg;
  logic [17:0]      tone_mag;
  logic [16:0]      tone_tmag;
  logic [NumW:0]    env_sum;
  logic [16:0]      fade_val;

  assign ev_rising  = gate_q | oneshot_q;
  assign ev_time_us = ev_rising ? DenW'(attack_q) * DenW'(arenv_pkg::MsToUs)
                                : DenW'(release_q) * DenW'(arenv_pkg::MsToUs);
  assign prod_rnd   = rnd16(prod_q);
  assign x_val      = env_q[Frac:Frac-16];
  assign x2_val     = prod_rnd[16:0];
  assign m_val      = sat17(rnd16(prod_q));
  assign a_val      = (manual_q > arenv_pkg::Q16One) ? arenv_pkg::Q16One : manual_q;
  assign burn_val   = 17'(arenv_pkg::Q16One - 17'(rnd16(prod_q)));
  assign pos_val    = PosW'(burn_q) * PosW'(Depth);
  assign pos_idx    = pos_val[PosW-1:16];
  assign idx_val    = (pos_idx >= (PosW-16)'(Depth)) ? AddrW'(Depth) : pos_idx[AddrW-1:0];
  assign frac_val   = (pos_idx >= (PosW-16)'(Depth)) ? 16'd0 : pos_val[15:0];
  assign idx_next   = (idx_q == AddrW'(Depth)) ? idx_q : idx_q + 1'b1;
  assign d_val      = (rom_q >= lo_q) ? rom_q - lo_q : 17'd0;
  assign soft_val   = sat17(21'(lo_q) + rnd16(prod_q));
  assign sat_num    = {1'b0, prod_q} + 37'(arenv_pkg::SatBias);
  assign sat_shr    = sat_num[36:arenv_pkg::SatShift];
  assign satq_val   = (sat_shr > 24'(arenv_pkg::SatQMax)) ? arenv_pkg::SatQMax
                                                          : sat_shr[19:0];
  assign sat_quo    = satr_q[39:arenv_pkg::SatRecipShift];
  assign sat_val    = (sat_quo > 18'(arenv_pkg::SatMax)) ? arenv_pkg::SatMax
                                                         : sat_quo[16:0];
  assign tone_neg   = tone_lift_q[17];
  assign tone_mag   = tone_neg ? 18'(19'h40000 - {1'b0, tone_lift_q}) : tone_lift_q;
  assign tone_tmag  = sat17(rnd16(prod_q));
  assign env_sum    = (NumW+1)'(env_q) + {1'b0, div_quo};
  assign fade_val   = sat17(rnd16(prod_q));
  assign out_load   = (state_q == arenv_pkg::ST_FIN) && (!out_valid_q || out_ready_i);

  arenv_div #(
    .NumW(NumW),
    .DenW(DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arenv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = arenv_pkg::ST_EVENT;
        end
      end
      arenv_pkg::ST_EVENT: begin
        if (action_q == arenv_pkg::ACT_TICK && ev_time_us != '0) begin
          state_d = arenv_pkg::ST_DIV;
        end else begin
          state_d = arenv_pkg::ST_X;
        end
      end
      arenv_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_d = arenv_pkg::ST_ADV;
        end
      end
      arenv_pkg::ST_ADV:    state_d = arenv_pkg::ST_X;
      arenv_pkg::ST_X:      state_d = arenv_pkg::ST_M1;
      arenv_pkg::ST_M1:     state_d = arenv_pkg::ST_M2;
      arenv_pkg::ST_M2:     state_d = arenv_pkg::ST_BURN;
      arenv_pkg::ST_BURN:   state_d = arenv_pkg::ST_IDX;
      arenv_pkg::ST_IDX:    state_d = arenv_pkg::ST_LO;
      arenv_pkg::ST_LO:     state_d = arenv_pkg::ST_HI;
      arenv_pkg::ST_HI:     state_d = arenv_pkg::ST_SOFT;
      arenv_pkg::ST_SOFT:   state_d = arenv_pkg::ST_SATDIV;
      arenv_pkg::ST_SATDIV: state_d = arenv_pkg::ST_SWAIT;
      arenv_pkg::ST_SWAIT:  state_d = arenv_pkg::ST_CON;
      arenv_pkg::ST_CON:    state_d = arenv_pkg::ST_TONE;
      arenv_pkg::ST_TONE:   state_d = arenv_pkg::ST_FADE;
      arenv_pkg::ST_FADE:   state_d = arenv_pkg::ST_FIN;
      arenv_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = arenv_pkg::ST_IDLE;
        end
      end
      default: state_d = arenv_pkg::ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    prod_en   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = {elapsed_q, Frac'(0)};
    div_den   = ev_time_us;
    rom_addr  = idx_val;
    unique case (state_q)
      arenv_pkg::ST_EVENT: begin
        div_start = (action_q == arenv_pkg::ACT_TICK) && (ev_time_us != '0);
      end
      arenv_pkg::ST_X: begin
        prod_en = 1'b1;
        mul_a   = 18'(x_val);
        mul_b   = 18'(x_val);
      end
      arenv_pkg::ST_M1: begin
        prod_en = 1'b1;
        mul_a   = 18'(x2_val);
        mul_b   = 18'd196608 - {x_val, 1'b0};
      end
      arenv_pkg::ST_M2: begin
        prod_en = 1'b1;
        mul_a   = 18'(arenv_pkg::Q16One - a_val);
        mul_b   = 18'(arenv_pkg::Q16One - m_val);
      end
      arenv_pkg::ST_LO: begin
        rom_addr = idx_next;
      end
      arenv_pkg::ST_HI: begin
        prod_en = 1'b1;
        mul_a   = 18'(d_val);
        mul_b   = 18'(frac_q);
      end
      arenv_pkg::ST_SOFT: begin
        prod_en = 1'b1;
        mul_a   = 18'(soft_val);
        mul_b   = 18'(sat_gain_q);
      end
      arenv_pkg::ST_CON: begin
        prod_en = 1'b1;
        mul_a   = 18'(soft_q);
        mul_b   = 18'(con_gain_q);
      end
      arenv_pkg::ST_TONE: begin
        prod_en = 1'b1;
        mul_a   = tone_mag;
        mul_b   = 18'(soft_q);
      end
      arenv_pkg::ST_FADE: begin
        prod_en = 1'b1;
        mul_a   = 18'(burn_q);
        mul_b   = 18'(fade_depth_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rom_q <= soft_rom[rom_addr];
    if (prod_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == arenv_pkg::ST_IDLE && in_valid_i) begin
      action_q  <= action_i;
      elapsed_q <= elapsed_us_i;
      level_q   <= level_i;
    end
    if (state_q == arenv_pkg::ST_EVENT) begin
      rising_q <= ev_rising;
    end
    if (state_q == arenv_pkg::ST_BURN) begin
      burn_q <= burn_val;
    end
    if (state_q == arenv_pkg::ST_IDX) begin
      idx_q  <= idx_val;
      frac_q <= frac_val;
    end
    if (state_q == arenv_pkg::ST_LO) begin
      lo_q <= rom_q;
    end
    if (state_q == arenv_pkg::ST_SOFT) begin
      soft_q <= soft_val;
    end
    if (state_q == arenv_pkg::ST_SATDIV) begin
      satq_q <= satq_val;
    end
    if (state_q == arenv_pkg::ST_SWAIT) begin
      satr_q <= satq_q * arenv_pkg::SatRecip;
    end
    if (state_q == arenv_pkg::ST_CON) begin
      satv_q <= sat_val;
    end
    if (state_q == arenv_pkg::ST_TONE) begin
      conv_q <= sat17(rnd16(prod_q));
    end
    if (state_q == arenv_pkg::ST_FADE) begin
      tonev_q <= tone_neg ? 18'(-{1'b0, tone_tmag}) : 18'(tone_tmag);
    end
    if (out_load) begin
      burn_res_q    <= burn_q;
      sat_out_q     <= satv_q;
      con_out_q     <= conv_q;
      tone_out_q    <= tonev_q;
      fade_out_q    <= fade_val;
      alpha_out_q   <= alpha_q ? burn_q : 17'd0;
      oneshot_out_q <= oneshot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= arenv_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      env_q        <= '0;
      gate_q       <= 1'b0;
      trig_q       <= 1'b0;
      oneshot_q    <= 1'b0;
      manual_q     <= 17'd0;
      attack_q     <= 10'd150;
      release_q    <= 13'd0;
      sat_gain_q   <= 17'd32768;
      con_gain_q   <= 17'd32768;
      tone_lift_q  <= 18'd0;
      fade_depth_q <= 17'd65536;
      alpha_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == arenv_pkg::ST_EVENT) begin
        unique case (action_q)
          arenv_pkg::ACT_TICK: begin
            if (ev_time_us == '0) begin
              if (ev_rising) begin
                env_q     <= EnvOne;
                oneshot_q <= 1'b0;
              end else begin
                env_q <= '0;
              end
            end
          end
          arenv_pkg::ACT_GATE: begin
            if (level_q && !gate_q) begin
              oneshot_q <= 1'b0;
            end
            gate_q <= level_q;
          end
          arenv_pkg::ACT_TRIG: begin
            if (level_q && !trig_q) begin
              oneshot_q <= 1'b1;
            end
            trig_q <= level_q;
          end
          default: begin
          end
        endcase
      end
      if (state_q == arenv_pkg::ST_ADV) begin
        if (rising_q) begin
          if (env_sum >= (NumW+1)'(EnvOne)) begin
            env_q     <= EnvOne;
            oneshot_q <= 1'b0;
          end else begin
            env_q <= env_sum[EnvW-1:0];
          end
        end else if (div_quo >= NumW'(env_q)) begin
          env_q <= '0;
        end else begin
          env_q <= env_q - div_quo[EnvW-1:0];
        end
      end
      if (cfg_valid_i) begin
        unique case (arenv_pkg::reg_e'(cfg_index_i))
          arenv_pkg::REG_MANUAL:   manual_q     <= cfg_data_i[16:0];
          arenv_pkg::REG_ATTACK:   attack_q     <= cfg_data_i[9:0];
          arenv_pkg::REG_RELEASE:  release_q    <= cfg_data_i[12:0];
          arenv_pkg::REG_SAT_GAIN: sat_gain_q   <= cfg_data_i[16:0];
          arenv_pkg::REG_CON_GAIN: con_gain_q   <= cfg_data_i[16:0];
          arenv_pkg::REG_TONE:     tone_lift_q  <= cfg_data_i[17:0];
          arenv_pkg::REG_FADE:     fade_depth_q <= cfg_data_i[16:0];
          arenv_pkg::REG_ALPHA:    alpha_q      <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  assign in_ready_o          = (state_q == arenv_pkg::ST_IDLE);
  assign cfg_ready_o         = 1'b1;
  assign out_valid_o         = out_valid_q;
  assign burn_level_o        = burn_res_q;
  assign saturation_amount_o = sat_out_q;
  assign contrast_amount_o   = con_out_q;
  assign tone_amount_o       = tone_out_q;
  assign black_fade_o        = fade_out_q;
  assign alpha_drop_o        = alpha_out_q;
  assign oneshot_active_o    = oneshot_out_q;

endmodule

[rtl/arenv_chk.sv]
module arenv_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [16:0]        burn_level_o,
  input logic [16:0]        saturation_amount_o,
  input logic signed [17:0] tone_amount_o,
  input logic [16:0]        alpha_drop_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(burn_level_o))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while busy");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alpha_drop_o == 17'd0) || (alpha_drop_o == burn_level_o))
    else $error("alpha drop not tied to burn level");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (burn_level_o <= 17'd65536) && (saturation_amount_o <= 17'd104858)
                    && (tone_amount_o <= 18'sd65536) && (tone_amount_o >= -18'sd65536))
    else $error("result out of range");

endmodule

bind ar_envelope_grade_params arenv_chk u_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .burn_level_o       (burn_level_o),
  .saturation_amount_o(saturation_amount_o),
  .tone_amount_o      (tone_amount_o),
  .alpha_drop_o       (alpha_drop_o)
);
